// File: design/assert_macros.svh
// Assertion macros shared by the neon recolor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define NRGA_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition must never be seen outside reset.
`define NRGA_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: design/nrga_pkg.sv
// Package: shared types and constants of the neon recolor glow accumulate block.
`default_nettype none

package nrga_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned PIXEL_W  = 32;
  localparam int unsigned FLAGS_W  = 8;
  localparam int unsigned TILE_W   = 16;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_PIXEL = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BORDER_MASK   = 3'd0,
    CFG_BORDER_COLOR  = 3'd1,
    CFG_LIGHT_COLOR   = 3'd2,
    CFG_MENU_COLOR    = 3'd3,
    CFG_SELECT_COLOR  = 3'd4
  } cfg_idx_e;

  localparam logic [PIXEL_W-1:0] COLOR_YELLOW  = 32'h00ffff00;
  localparam logic [PIXEL_W-1:0] COLOR_DARKRED = 32'h00880000;
  localparam logic [PIXEL_W-1:0] COLOR_RED     = 32'h00ff0000;

  localparam logic [CHAN_W-1:0] AVG_HI = 8'd150;
  localparam logic [CHAN_W-1:0] AVG_LO = 8'd50;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  // output queue
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned OUT_PTR_W = 3;
  localparam int unsigned OUT_CNT_W = 4;

  typedef struct packed {
    logic [CHAN_W-1:0] count;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } entry_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] out_pixel;
    entry_t             acc;
  } result_t;

endpackage

`default_nettype wire

// File: design/nrga_in_if.sv
// Interface: input item channel (valid/ready with pixel command payload).
`default_nettype none

interface nrga_in_if;
  logic                             valid;
  logic                             ready;
  logic [nrga_pkg::CMD_W-1:0]       cmd;
  logic [nrga_pkg::PIXEL_W-1:0]     src_pixel;
  logic [nrga_pkg::FLAGS_W-1:0]     pixel_flags;
  logic [nrga_pkg::TILE_W-1:0]      tile_index;

  modport source (output valid, cmd, src_pixel, pixel_flags, tile_index, input ready);
  modport sink   (input valid, cmd, src_pixel, pixel_flags, tile_index, output ready);
endinterface

`default_nettype wire

// File: design/nrga_out_if.sv
// Interface: result channel (valid/ready with recolored pixel and tile entry).
`default_nettype none

interface nrga_out_if;
  logic                          valid;
  logic                          ready;
  logic [nrga_pkg::PIXEL_W-1:0]  out_pixel;
  logic [nrga_pkg::CHAN_W-1:0]   acc_count;
  logic [nrga_pkg::CHAN_W-1:0]   acc_red;
  logic [nrga_pkg::CHAN_W-1:0]   acc_green;
  logic [nrga_pkg::CHAN_W-1:0]   acc_blue;

  modport source (output valid, out_pixel, acc_count, acc_red, acc_green, acc_blue,
                  input ready);
  modport sink   (input valid, out_pixel, acc_count, acc_red, acc_green, acc_blue,
                  output ready);
endinterface

`default_nettype wire

// File: design/nrga_idx_reduce.sv
// Two-stage reduction of the tile index modulo the accumulator depth.
`default_nettype none

module nrga_idx_reduce #(
  parameter int unsigned TILE_ENTRIES = 65536
) (
  input  wire logic                              clk_i,
  input  wire logic [nrga_pkg::TILE_W-1:0]       tile_i,
  output logic      [$clog2(TILE_ENTRIES)-1:0]   idx_o
);

  localparam int unsigned AW = $clog2(TILE_ENTRIES);
  localparam bit DIRECT = (TILE_ENTRIES >= (1 << nrga_pkg::TILE_W)) ||
                          ((TILE_ENTRIES & (TILE_ENTRIES - 1)) == 0);

  if (DIRECT) begin : g_direct
    logic [nrga_pkg::TILE_W-1:0] t1_q;
    logic [nrga_pkg::TILE_W-1:0] t2_q;

    always_ff @(posedge clk_i) begin
      t1_q <= tile_i;
      t2_q <= t1_q;
    end

    assign idx_o = AW'(t2_q);
  end else begin : g_recip
    // quotient estimate by floor(2^32/N), off by at most one
    localparam logic [47:0] RECIP = 48'((64'd1 << 32) / TILE_ENTRIES);
    localparam logic [nrga_pkg::TILE_W-1:0] MODN = nrga_pkg::TILE_W'(TILE_ENTRIES);

    logic [47:0]                 prod;
    logic [31:0]                 mprod;
    logic [nrga_pkg::TILE_W-1:0] q_q;
    logic [nrga_pkg::TILE_W-1:0] t1_q;
    logic [nrga_pkg::TILE_W-1:0] r_q;
    logic [nrga_pkg::TILE_W-1:0] idx;

    assign prod  = 48'(tile_i) * RECIP;
    assign mprod = 32'(q_q) * 32'(MODN);

    always_ff @(posedge clk_i) begin
      q_q  <= prod[47:32];
      t1_q <= tile_i;
      r_q  <= t1_q - mprod[nrga_pkg::TILE_W-1:0];
    end

    assign idx   = (r_q >= MODN) ? (r_q - MODN) : r_q;
    assign idx_o = idx[AW-1:0];
  end

endmodule

`default_nettype wire

// File: design/neon_recolor_glow_accumulate_core.sv
// Top level: neon pixel recolor with read-modify-write tile accumulator memory.
//
//  channel   dir  handshake            payload
//  in_bus    in   valid/ready          cmd, src_pixel, pixel_flags, tile_index
//  out_bus   out  valid/ready          out_pixel, acc_count/red/green/blue
//  cfg       in   cfg_we_i (no ready)  cfg_idx_i, cfg_wdata_i
//
// One transaction per cycle while in_bus.ready is high; a result is presented once queued.
// Three pipeline stages feed one tile memory port pair (read in stage 2,
// write in stage 3, last write forwarded to the next item).
// After reset a clearing pass zeroes every tile memory entry;
// in_bus.ready stays low meanwhile, configuration writes are still taken.
// An 8-entry result queue absorbs output stalls; ready drops once queued plus in-flight reach 8.
`default_nettype none

`include "assert_macros.svh"

module neon_recolor_glow_accumulate_core #(
  parameter int unsigned TILE_ENTRIES = 65536
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [nrga_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [nrga_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  nrga_in_if.sink                                  in_bus,
  nrga_out_if.source                               out_bus
);

  localparam int unsigned AW = $clog2(TILE_ENTRIES);
  localparam int unsigned CW = nrga_pkg::CHAN_W;
  localparam int unsigned PW = nrga_pkg::PIXEL_W;
  localparam logic [9:0] DIV3_MUL = 10'd683;
  localparam int unsigned DIV3_SHIFT = 11;

  typedef enum logic [2:0] {
    SEL_BLACK,
    SEL_YELLOW,
    SEL_DARKRED,
    SEL_RED,
    SEL_AVG
  } sel_e;

  function automatic logic [CW-1:0] sat_add_half(input logic [CW-1:0] acc,
                                                 input logic [CW-1:0] ch);
    logic [CW:0] s;
    s = {1'b0, acc} + {2'b0, ch[CW-1:1]};
    return s[CW] ? nrga_pkg::CHAN_MAX : s[CW-1:0];
  endfunction

  // configuration
  logic [nrga_pkg::FLAGS_W-1:0] mask_q;
  logic [PW-1:0] bcol_q, lcol_q, mcol_q, scol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= nrga_pkg::FLAGS_W'(1);
      bcol_q <= '0;
      lcol_q <= '0;
      mcol_q <= '0;
      scol_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nrga_pkg::CFG_BORDER_MASK:  mask_q <= cfg_wdata_i[nrga_pkg::FLAGS_W-1:0];
        nrga_pkg::CFG_BORDER_COLOR: bcol_q <= cfg_wdata_i;
        nrga_pkg::CFG_LIGHT_COLOR:  lcol_q <= cfg_wdata_i;
        nrga_pkg::CFG_MENU_COLOR:   mcol_q <= cfg_wdata_i;
        nrga_pkg::CFG_SELECT_COLOR: scol_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clearing pass
  logic          clr_busy_q;
  logic [AW-1:0] clr_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_ptr_q  <= '0;
    end else if (clr_busy_q) begin
      clr_ptr_q <= clr_ptr_q + AW'(1);
      if (clr_ptr_q == AW'(TILE_ENTRIES - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // stage valids and queue control
  logic v1_q, v2_q, v3_q;
  logic [nrga_pkg::OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [nrga_pkg::OUT_CNT_W-1:0] cnt_q;
  logic [nrga_pkg::OUT_CNT_W-1:0] credits;
  logic accept, push, pop;

  assign credits = cnt_q + {3'b0, v1_q} + {3'b0, v2_q} + {3'b0, v3_q};
  assign in_bus.ready = !clr_busy_q &&
                        (credits < nrga_pkg::OUT_CNT_W'(nrga_pkg::OUT_DEPTH));
  assign accept = in_bus.valid && in_bus.ready;
  assign push   = v3_q;
  assign pop    = out_bus.valid && out_bus.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (push) wr_ptr_q <= wr_ptr_q + nrga_pkg::OUT_PTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + nrga_pkg::OUT_PTR_W'(1);
      if (push && !pop) begin
        cnt_q <= cnt_q + nrga_pkg::OUT_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - nrga_pkg::OUT_CNT_W'(1);
      end
    end
  end

  // stage 1: captured transaction
  logic [nrga_pkg::CMD_W-1:0]   cmd1_q;
  logic [PW-1:0]                px1_q;
  logic [nrga_pkg::FLAGS_W-1:0] flags1_q;
  logic [9:0] sum1;
  logic       border1;
  sel_e       sel1;

  always_ff @(posedge clk_i) begin
    cmd1_q   <= in_bus.cmd;
    px1_q    <= in_bus.src_pixel;
    flags1_q <= in_bus.pixel_flags;
  end

  assign sum1 = 10'(px1_q[23:16]) + 10'(px1_q[15:8]) + 10'(px1_q[7:0]);
  assign border1 = |(flags1_q & mask_q);

  always_comb begin
    if (flags1_q == '0) begin
      sel1 = SEL_BLACK;
    end else if (border1 && px1_q == bcol_q) begin
      sel1 = SEL_YELLOW;
    end else if (border1 && px1_q == lcol_q) begin
      sel1 = SEL_DARKRED;
    end else if (border1 && px1_q == mcol_q) begin
      sel1 = SEL_YELLOW;
    end else if (border1 && px1_q == scol_q) begin
      sel1 = SEL_RED;
    end else begin
      sel1 = SEL_AVG;
    end
  end

  // stage 2: channel average
  logic [nrga_pkg::CMD_W-1:0] cmd2_q;
  logic [CW-1:0]              x2_q;
  sel_e                       sel2_q;
  logic [9:0]                 sum2_q;
  logic [19:0]                vmul;
  logic [AW-1:0]              idx2;

  always_ff @(posedge clk_i) begin
    cmd2_q <= cmd1_q;
    x2_q   <= px1_q[31:24];
    sel2_q <= sel1;
    sum2_q <= sum1;
  end

  assign vmul = 20'(sum2_q) * 20'(DIV3_MUL);

  nrga_idx_reduce #(
    .TILE_ENTRIES(TILE_ENTRIES)
  ) u_idx (
    .clk_i  (clk_i),
    .tile_i (in_bus.tile_index),
    .idx_o  (idx2)
  );

  // tile memory
  logic [PW-1:0] tile_mem [TILE_ENTRIES];
  logic [PW-1:0] rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [PW-1:0] mem_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) tile_mem[mem_wa] <= mem_wd;
    rd_q <= tile_mem[idx2];
  end

  // stage 3: recolor, accumulate, write back
  logic [nrga_pkg::CMD_W-1:0] cmd3_q;
  logic [CW-1:0]              x3_q;
  sel_e                       sel3_q;
  logic [CW-1:0]              avg3_q;
  logic [AW-1:0]              idx3_q;

  always_ff @(posedge clk_i) begin
    cmd3_q <= cmd2_q;
    x3_q   <= x2_q;
    sel3_q <= sel2_q;
    avg3_q <= vmul[DIV3_SHIFT +: CW];
    idx3_q <= idx2;
  end

  logic               wf_v_q;
  logic [AW-1:0]      wf_idx_q;
  nrga_pkg::entry_t   wf_data_q;
  nrga_pkg::entry_t   cur_e, new_e;
  logic [PW-1:0]      color;
  logic [CW-1:0]      ar, ag, ab;
  logic [PW-1:0]      res_px;
  logic               item_wr;
  nrga_pkg::result_t  res3;

  assign cur_e = (wf_v_q && wf_idx_q == idx3_q) ? wf_data_q : nrga_pkg::entry_t'(rd_q);

  always_comb begin
    ar = avg3_q;
    ag = avg3_q;
    ab = avg3_q;
    if (avg3_q > nrga_pkg::AVG_HI) begin
      ag = {1'b0, avg3_q[CW-1:1]};
      ab = '0;
    end else if (avg3_q > nrga_pkg::AVG_LO) begin
      ar = '0;
      ag = {1'b0, avg3_q[CW-1:1]};
    end
    case (sel3_q)
      SEL_BLACK:   color = '0;
      SEL_YELLOW:  color = nrga_pkg::COLOR_YELLOW;
      SEL_DARKRED: color = nrga_pkg::COLOR_DARKRED;
      SEL_RED:     color = nrga_pkg::COLOR_RED;
      default:     color = {x3_q, ar, ag, ab};
    endcase
  end

  always_comb begin
    new_e   = cur_e;
    res_px  = '0;
    item_wr = 1'b0;
    case (cmd3_q)
      nrga_pkg::CMD_PIXEL: begin
        res_px      = color;
        item_wr     = 1'b1;
        new_e.count = cur_e.count + CW'(1);
        new_e.red   = sat_add_half(cur_e.red, color[23:16]);
        new_e.green = sat_add_half(cur_e.green, color[15:8]);
        new_e.blue  = sat_add_half(cur_e.blue, color[7:0]);
      end
      nrga_pkg::CMD_CLEAR: begin
        item_wr = 1'b1;
        new_e   = '0;
      end
      default: ;
    endcase
  end

  assign res3.out_pixel = res_px;
  assign res3.acc       = new_e;

  assign mem_we = clr_busy_q || (v3_q && item_wr);
  assign mem_wa = clr_busy_q ? clr_ptr_q : idx3_q;
  assign mem_wd = clr_busy_q ? '0 : PW'(new_e);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wf_v_q <= 1'b0;
    end else begin
      wf_v_q <= v3_q && item_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    wf_idx_q  <= idx3_q;
    wf_data_q <= new_e;
  end

  // result queue
  nrga_pkg::result_t out_q [nrga_pkg::OUT_DEPTH];
  nrga_pkg::result_t head;

  always_ff @(posedge clk_i) begin
    if (push) out_q[wr_ptr_q] <= res3;
  end

  assign head              = out_q[rd_ptr_q];
  assign out_bus.valid     = (cnt_q != '0);
  assign out_bus.out_pixel = head.out_pixel;
  assign out_bus.acc_count = head.acc.count;
  assign out_bus.acc_red   = head.acc.red;
  assign out_bus.acc_green = head.acc.green;
  assign out_bus.acc_blue  = head.acc.blue;

  `NRGA_NEVER(a_no_accept_in_clear, clk_i, rst_ni, clr_busy_q && accept)
  `NRGA_ASSERT(a_credit_bound, clk_i, rst_ni,
               credits <= nrga_pkg::OUT_CNT_W'(nrga_pkg::OUT_DEPTH))
  `NRGA_NEVER(a_queue_overflow, clk_i, rst_ni,
              push && !pop && cnt_q == nrga_pkg::OUT_CNT_W'(nrga_pkg::OUT_DEPTH))
  `NRGA_ASSERT(a_fwd_tracks_write, clk_i, rst_ni,
               (v3_q && item_wr && !clr_busy_q) |=> wf_v_q)

endmodule

`default_nettype wire
